FILE: rtl/core/ultrasonic_echo_ranger_defines.svh
// Assertion macros shared by the ultrasonic echo ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define UER_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UER_ASSERT_SAME(lbl, ante, cons, msg)
`define UER_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/uer_pkg.sv
// Shared constants and types for the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

    // Width of the wrapping microsecond counter and of all time stamps.
    localparam int TIME_BITS = 32;

    // Field and register widths.
    localparam int DIST_W      = 27;
    localparam int THRESH_W    = 10;
    localparam int PERIOD_W    = 20;
    localparam int TWIDTH_W    = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] CFG_OBSTACLE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_PERIOD     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_WIDTH      = 2'd2;

    // Register values after reset.
    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd30;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd60000;
    localparam logic [TWIDTH_W-1:0] TWIDTH_RESET = 8'd10;

    // Echo round trip time per centimeter, and the largest reportable distance.
    localparam int ECHO_DIVISOR = 58;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Reciprocal of the divisor: floor(2^(TIME_BITS+5) / 58) fits in TIME_BITS
    // bits and gives a quotient that is exact or one too small.
    localparam int RECIP_SHIFT = TIME_BITS + 5;
    localparam logic [2*TIME_BITS-1:0] RECIP_WIDE =
        ((2*TIME_BITS)'(1) << RECIP_SHIFT) / ECHO_DIVISOR;
    localparam logic [TIME_BITS-1:0] RECIP = RECIP_WIDE[TIME_BITS-1:0];

    // The remainder before correction stays below twice the divisor.
    localparam int REM_W = 7;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [DIST_W-1:0]    dist_t;

endpackage

`default_nettype wire

FILE: rtl/core/uer_channels_if.sv
// Handshake channel interfaces for the echo samples, results and register writes.
`default_nettype none

// One sampled echo level per microsecond tick.
interface uer_echo_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink (input valid, input echo_level, output ready);
endinterface

// One ranging result per tick.
interface uer_result_if import uer_pkg::*; ();
    logic          valid;
    logic          ready;
    logic          trigger_level;
    logic          distance_valid;
    dist_t         range_cm;
    logic          obstacle;

    modport source (output valid, output trigger_level, output distance_valid,
                    output range_cm, output obstacle, input ready);
    modport sink (input valid, input trigger_level, input distance_valid,
                  input range_cm, input obstacle, output ready);
endinterface

// Register write channel.
interface uer_cfg_if import uer_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: trigger timing, echo timing and distance.
//
//   Channel  Direction  Carries
//   echo     in         echo_level, one sample per microsecond tick
//   result   out        trigger_level, distance_valid, range_cm, obstacle
//   cfg      in         reg_index, wr_data (threshold, trigger period, trigger width)
//
// One tick is accepted per clock cycle unless the pipeline is stalled.
// The four stages are: timer and edge logic, reciprocal multiply, remainder,
// and correction with the obstacle compare. Each stage holds its transaction
// only while the next one is full, so a stalled result still lets earlier
// stages fill. Reset clears the timers, the stage valids and the last distance.
// Register writes are always taken in the cycle they are offered.
`default_nettype none
`include "ultrasonic_echo_ranger_defines.svh"

module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    uer_echo_if.sink     echo,
    uer_result_if.source result,
    uer_cfg_if.sink      cfg
);

    // Configuration registers.
    logic [THRESH_W-1:0] thresh_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TWIDTH_W-1:0] twidth_reg;

    // Timer and echo state.
    time_t               time_now_reg, time_now_next;
    time_t               last_trigger_reg, last_trigger_next;
    time_t               echo_start_reg, echo_start_next;
    logic                echo_prev_reg, echo_prev_next;
    logic [TWIDTH_W-1:0] trigger_left_reg, trigger_left_next;

    // Stage A: trigger level, falling edge flag and echo duration.
    logic  a_valid_reg;
    logic  a_trig_reg;
    logic  a_fall_reg;
    time_t a_dur_reg;

    // Stage B: product with the reciprocal.
    logic                  b_valid_reg;
    logic                  b_trig_reg;
    logic                  b_fall_reg;
    time_t                 b_dur_reg;
    logic [2*TIME_BITS-1:0] b_prod_reg;

    // Stage C: estimated quotient and its remainder.
    logic             c_valid_reg;
    logic             c_trig_reg;
    logic             c_fall_reg;
    time_t            c_quot_reg;
    logic [REM_W-1:0] c_rem_reg;

    // Result register; distance and obstacle also hold the latest measurement.
    logic  out_valid_reg;
    logic  out_trig_reg;
    logic  out_dvalid_reg;
    dist_t out_dist_reg, out_dist_next;
    logic  out_obst_reg, out_obst_next;

    // Stage handshakes.
    logic a_ready, b_ready, c_ready, d_ready;
    logic in_fire;

    // Combinational values of the first stage.
    time_t               elapsed;
    logic                fire;
    logic [TWIDTH_W-1:0] left_armed;
    logic                trig;
    logic                rise, fall;

    // Later stage arithmetic.
    time_t quot_est;
    time_t rem_wide;
    time_t quot_fix;
    dist_t dist_sat;

    // Each stage can take a transaction when it is empty or moving on.
    assign d_ready = !out_valid_reg || result.ready;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;

    assign echo.ready = a_ready;
    assign in_fire    = echo.valid && a_ready;
    assign cfg.ready  = 1'b1;

    // Trigger decision, pulse countdown and echo edge detection for this tick.
    always_comb
    begin
        elapsed    = time_now_reg - last_trigger_reg;
        fire       = (trigger_left_reg == '0) && (elapsed > TIME_BITS'(period_reg));
        left_armed = fire ? twidth_reg : trigger_left_reg;
        trig       = (left_armed != '0);
        rise       = echo.echo_level && !echo_prev_reg;
        fall       = !echo.echo_level && echo_prev_reg;

        time_now_next     = time_now_reg;
        last_trigger_next = last_trigger_reg;
        echo_start_next   = echo_start_reg;
        echo_prev_next    = echo_prev_reg;
        trigger_left_next = trigger_left_reg;
        if (in_fire)
        begin
            time_now_next     = time_now_reg + 1'b1;
            last_trigger_next = fire ? time_now_reg : last_trigger_reg;
            echo_start_next   = rise ? time_now_reg : echo_start_reg;
            echo_prev_next    = echo.echo_level;
            trigger_left_next = trig ? (left_armed - 1'b1) : left_armed;
        end
    end

    // Timer state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg     <= '0;
            last_trigger_reg <= '0;
            echo_start_reg   <= '0;
            echo_prev_reg    <= 1'b0;
            trigger_left_reg <= '0;
            thresh_reg       <= THRESH_RESET;
            period_reg       <= PERIOD_RESET;
            twidth_reg       <= TWIDTH_RESET;
        end
        else
        begin
            time_now_reg     <= time_now_next;
            last_trigger_reg <= last_trigger_next;
            echo_start_reg   <= echo_start_next;
            echo_prev_reg    <= echo_prev_next;
            trigger_left_reg <= trigger_left_next;
            if (cfg.valid)
            begin
                unique case (cfg.reg_index)
                    CFG_OBSTACLE_THRESHOLD: thresh_reg <= cfg.wr_data[THRESH_W-1:0];
                    CFG_TRIGGER_PERIOD:     period_reg <= cfg.wr_data[PERIOD_W-1:0];
                    CFG_TRIGGER_WIDTH:      twidth_reg <= cfg.wr_data[TWIDTH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Quotient estimate and remainder, then the one-step correction and clamp.
    always_comb
    begin
        quot_est = TIME_BITS'(b_prod_reg >> RECIP_SHIFT);
        rem_wide = b_dur_reg - (quot_est * TIME_BITS'(ECHO_DIVISOR));
        quot_fix = c_quot_reg + TIME_BITS'(c_rem_reg >= REM_W'(ECHO_DIVISOR));
        if (quot_fix > TIME_BITS'(DIST_MAX))
        begin
            dist_sat = DIST_MAX;
        end
        else
        begin
            dist_sat = quot_fix[DIST_W-1:0];
        end

        out_dist_next = out_dist_reg;
        out_obst_next = out_obst_reg;
        if (c_fall_reg)
        begin
            out_dist_next = dist_sat;
            out_obst_next = (dist_sat != '0) && (dist_sat < DIST_W'(thresh_reg));
        end
    end

    // Stage valids and the measurement that the result register keeps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_dist_reg  <= '0;
            out_obst_reg  <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_fire;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                out_valid_reg <= c_valid_reg;
                if (c_valid_reg)
                begin
                    out_dist_reg <= out_dist_next;
                    out_obst_reg <= out_obst_next;
                end
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_trig_reg <= trig;
            a_fall_reg <= fall;
            a_dur_reg  <= time_now_reg - echo_start_reg;
        end
        if (b_ready && a_valid_reg)
        begin
            b_trig_reg <= a_trig_reg;
            b_fall_reg <= a_fall_reg;
            b_dur_reg  <= a_dur_reg;
            b_prod_reg <= a_dur_reg * RECIP;
        end
        if (c_ready && b_valid_reg)
        begin
            c_trig_reg <= b_trig_reg;
            c_fall_reg <= b_fall_reg;
            c_quot_reg <= quot_est;
            c_rem_reg  <= rem_wide[REM_W-1:0];
        end
        if (d_ready && c_valid_reg)
        begin
            out_trig_reg   <= c_trig_reg;
            out_dvalid_reg <= c_fall_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.trigger_level  = out_trig_reg;
    assign result.distance_valid = out_dvalid_reg;
    assign result.range_cm       = out_dist_reg;
    assign result.obstacle       = out_obst_reg;

    // An obstacle is only reported for a nonzero distance.
    `UER_ASSERT_SAME(a_obstacle_nonzero, result.valid && result.obstacle,
        result.range_cm != '0, "obstacle reported with zero distance")

    // The reciprocal estimate is never more than one short.
    `UER_ASSERT_SAME(a_rem_bound, c_valid_reg,
        c_rem_reg < REM_W'(2 * ECHO_DIVISOR), "quotient estimate off by more than one")

    // A stalled result keeps the stored measurement.
    `UER_ASSERT_NEXT(a_dist_hold, out_valid_reg && !result.ready,
        $stable(out_dist_reg) && $stable(out_obst_reg), "measurement changed during stall")

endmodule

`default_nettype wire
